// ===== rtl/pds_pkg.sv =====
`timescale 1ns / 1ps
// pds_pkg: word types, request codes and cell index helper for the
// digraph substitution block. No dependencies.
package pds_pkg;

    localparam int ROWS_DEF  = 10;
    localparam int COLS_DEF  = 9;
    localparam int CHAR_W    = 8;
    localparam int NIB_W     = 4;
    localparam int POS_W     = 2 * NIB_W;    // {row, col}
    localparam int CELL_W    = 8;            // flat cell index, up to 16 x 16
    localparam int CELL_X_W  = CELL_W + 1;
    localparam int NUM_CHARS = 1 << CHAR_W;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_ENC  = 2'd1;
    localparam logic [1:0] REQ_DEC  = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [NIB_W-1:0]  cell_row;
        logic [NIB_W-1:0]  cell_col;
        logic [CHAR_W-1:0] char_first;
        logic [CHAR_W-1:0] char_second;
    } req_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_first;
        logic [CHAR_W-1:0] out_second;
        logic              status;
    } rsp_t;

    // key cell write leaving the first stage
    typedef struct packed {
        logic              go;
        logic [CHAR_W-1:0] ch;
        logic [POS_W-1:0]  pos;
        logic [CELL_W-1:0] slot;
    } load_cmd_t;

    // row-major flat index of a cell
    function automatic logic [CELL_W-1:0] cell_index(
        input logic [NIB_W-1:0] row,
        input logic [NIB_W-1:0] col,
        input logic [NIB_W:0]   cols
    );
        logic [CELL_X_W-1:0] acc;
        acc = CELL_X_W'(row) * CELL_X_W'(cols) + CELL_X_W'(col);
        return acc[CELL_W-1:0];
    endfunction

endpackage

// ===== rtl/pds_ram.sv =====
`timescale 1ns / 1ps
// pds_ram: one write port, NRD registered read ports, write-first on a
// same-cycle address match. Depends on pds_pkg for defaults.
module pds_ram import pds_pkg::*; #(
    parameter int DEPTH = NUM_CHARS,
    parameter int WIDTH = CHAR_W,
    parameter int NRD   = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr [NRD],
    output logic [WIDTH-1:0]         rdata [NRD]
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg [NRD];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    for (genvar i = 0; i < NRD; i++)
    begin : g_rd
        always_ff @(posedge clk)
        begin
            if (re)
            begin
                rdata_reg[i] <= (we && (waddr == raddr[i])) ? wdata : mem[raddr[i]];
            end
        end
        assign rdata[i] = rdata_reg[i];
    end

endmodule

// ===== rtl/pds_map_state.sv =====
`timescale 1ns / 1ps
// pds_map_state: present bits of the char map, cell-written bits and owner
// bits of the key square, and the load update rules. Depends on pds_pkg.
module pds_map_state import pds_pkg::*; #(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  load_cmd_t         load_cmd,
    input  logic [CHAR_W-1:0] old_rd,
    input  logic [POS_W-1:0]  cur_rd,
    output logic              pos_we,
    input  logic [CHAR_W-1:0] qry_ch [2],
    output logic              qry_present [2],
    input  logic [CELL_W-1:0] qry_cell [2],
    output logic              qry_written [2]
);

    localparam int CELLS = ROWS * COLS;
    localparam int CW    = $clog2(CELLS);
    localparam logic [NIB_W:0] COLS_N = (NIB_W + 1)'(COLS);

    logic [NUM_CHARS-1:0] present_reg;
    logic [CELLS-1:0]     own_reg;     // cell holds the map entry of its char
    logic [CELLS-1:0]     kval_reg;

    logic [CW-1:0]     cell_w;
    logic [CW-1:0]     cur_cell;
    logic [CELL_W-1:0] cur_idx;
    logic [CHAR_W-1:0] old_ch;
    logic              own_hit;
    logic              ch_present;
    logic              move;
    logic              clear_old;

    always_comb
    begin
        cell_w     = load_cmd.slot[CW-1:0];
        old_ch     = kval_reg[cell_w] ? old_rd : '0;
        own_hit    = own_reg[cell_w];
        clear_old  = own_hit && (old_ch != load_cmd.ch);
        ch_present = present_reg[load_cmd.ch];
        // earlier row-major cell keeps the entry; {row,col} compares in that order
        move       = !ch_present || (load_cmd.pos < cur_rd);
        cur_idx    = cell_index(cur_rd[POS_W-1:NIB_W], cur_rd[NIB_W-1:0], COLS_N);
        cur_cell   = cur_idx[CW-1:0];
    end

    assign pos_we = load_cmd.go && move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            own_reg     <= '0;
            kval_reg    <= '0;
        end
        else if (load_cmd.go)
        begin
            kval_reg[cell_w] <= 1'b1;
            if (clear_old)
            begin
                present_reg[old_ch] <= 1'b0;
            end
            if (move)
            begin
                present_reg[load_cmd.ch] <= 1'b1;
                if (ch_present)
                begin
                    own_reg[cur_cell] <= 1'b0;
                end
                own_reg[cell_w] <= 1'b1;
            end
            else
            begin
                own_reg[cell_w] <= own_hit && (old_ch == load_cmd.ch);
            end
        end
    end

    for (genvar i = 0; i < 2; i++)
    begin : g_qry
        assign qry_present[i] = present_reg[qry_ch[i]];
        assign qry_written[i] = kval_reg[qry_cell[i][CW-1:0]];
    end

    a_own_le_present: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(own_reg) <= $countones(present_reg))
        else $error("more owner cells than present chars");

    a_load_marks_cell: assert property (@(posedge clk) disable iff (!rst_n)
        load_cmd.go |=> kval_reg[$past(cell_w)])
        else $error("loaded cell not marked written");

endmodule

// ===== rtl/pds_cell_sel.sv =====
`timescale 1ns / 1ps
// pds_cell_sel: digraph substitution rules, from the two char positions to
// the two key square cells to read. Depends on pds_pkg.
module pds_cell_sel import pds_pkg::*; #(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  logic [POS_W-1:0]  pos_first,
    input  logic [POS_W-1:0]  pos_second,
    input  logic              decrypt,
    output logic [CELL_W-1:0] cell_first,
    output logic [CELL_W-1:0] cell_second
);

    localparam logic [NIB_W:0] ROWS_N = (NIB_W + 1)'(ROWS);
    localparam logic [NIB_W:0] COLS_N = (NIB_W + 1)'(COLS);

    function automatic logic [NIB_W-1:0] wrap_step(
        input logic [NIB_W-1:0] v,
        input logic [NIB_W:0]   lim,
        input logic             dec
    );
        logic [NIB_W:0] up;
        up = (NIB_W + 1)'(v) + (NIB_W + 1)'(1);
        if (dec)
        begin
            return (v == '0) ? NIB_W'(lim - (NIB_W + 1)'(1)) : v - NIB_W'(1);
        end
        return (up == lim) ? '0 : up[NIB_W-1:0];
    endfunction

    logic [NIB_W-1:0] fr, fc, lr, lc;
    logic [NIB_W-1:0] dr, dc;
    logic [NIB_W-1:0] r1, c1, r2, c2;

    always_comb
    begin
        fr = pos_first[POS_W-1:NIB_W];
        fc = pos_first[NIB_W-1:0];
        lr = pos_second[POS_W-1:NIB_W];
        lc = pos_second[NIB_W-1:0];
        dr = (fr >= lr) ? fr - lr : lr - fr;
        dc = (fc >= lc) ? fc - lc : lc - fc;
        if (fr == lr)
        begin
            r1 = fr;
            c1 = wrap_step(fc, COLS_N, decrypt);
            r2 = lr;
            c2 = wrap_step(lc, COLS_N, decrypt);
        end
        else if (fc == lc)
        begin
            r1 = wrap_step(fr, ROWS_N, decrypt);
            c1 = fc;
            r2 = wrap_step(lr, ROWS_N, decrypt);
            c2 = lc;
        end
        else if (dr <= dc)
        begin
            // wide rectangle: keep rows, swap columns
            r1 = fr;
            c1 = lc;
            r2 = lr;
            c2 = fc;
        end
        else
        begin
            // tall rectangle: keep columns, swap rows
            r1 = lr;
            c1 = fc;
            r2 = fr;
            c2 = lc;
        end
        cell_first  = cell_index(r1, c1, COLS_N);
        cell_second = cell_index(r2, c2, COLS_N);
    end

endmodule

// ===== rtl/playfair_digraph_substitution.sv =====
`timescale 1ns / 1ps
// Top level of the digraph substitution block.
// Depends on pds_pkg, pds_ram, pds_map_state and pds_cell_sel.
//
// One request word is taken every clock cycle while req_stall is low, loads
// and digraphs alike. A digraph word reads the char map as it is accepted
// (two read ports, one per character), then, once the result register has
// room, the two substituted cells from a key square copy with two read ports.
// A load writes its cell in the cycle after acceptance and gives no result; a
// second copy of the key square supplies the replaced character. Reset clears
// the present and cell-written bits at once, so no clearing pass is needed.
// Input stall rises only while a digraph waits behind a stalled result.
module playfair_digraph_substitution import pds_pkg::*; #(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_word,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_word
);

    localparam int CELLS = ROWS * COLS;
    localparam int CW    = $clog2(CELLS);
    localparam logic [NIB_W:0] ROWS_N = (NIB_W + 1)'(ROWS);
    localparam logic [NIB_W:0] COLS_N = (NIB_W + 1)'(COLS);

    logic s1_valid_reg, s1_load_reg;
    req_t s1_word_reg;
    logic out_valid_reg, out_err_reg;
    logic [1:0] out_kv_reg;

    logic req_acc, in_keep, in_range;
    logic out_free, s1_adv, dg_go;
    logic [CELL_W-1:0] req_cell, s1_cell;
    load_cmd_t load_cmd;
    logic pos_we;

    logic [CHAR_W-1:0] pm_raddr [2];
    logic [POS_W-1:0]  pm_rdata [2];
    logic [CW-1:0]     kb_raddr [1];
    logic [CHAR_W-1:0] kb_rdata [1];
    logic [CW-1:0]     ka_raddr [2];
    logic [CHAR_W-1:0] ka_rdata [2];

    logic [CELL_W-1:0] tgt_cell [2];
    logic [CHAR_W-1:0] qry_ch [2];
    logic              qry_present [2];
    logic              qry_written [2];

    assign req_cell = cell_index(req_word.cell_row, req_word.cell_col, COLS_N);
    assign in_range = ({1'b0, req_word.cell_row} < ROWS_N)
                   && ({1'b0, req_word.cell_col} < COLS_N);

    always_comb
    begin
        case (req_word.req_type)
            REQ_LOAD:         in_keep = in_range;
            REQ_ENC, REQ_DEC: in_keep = 1'b1;
            default:          in_keep = 1'b0;
        endcase
    end

    // loads always leave stage 1; digraphs need room in the result register
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign s1_adv    = s1_load_reg || out_free;
    assign req_stall = s1_valid_reg && !s1_adv;
    assign req_acc   = req_valid && !req_stall;
    assign dg_go     = s1_valid_reg && !s1_load_reg && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_load_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_acc)
            begin
                s1_valid_reg <= in_keep;
                s1_load_reg  <= (req_word.req_type == REQ_LOAD);
            end
            else if (s1_valid_reg && s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (dg_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            s1_word_reg <= req_word;
        end
        if (dg_go)
        begin
            out_err_reg <= !(qry_present[0] && qry_present[1]);
            out_kv_reg  <= {qry_written[1], qry_written[0]};
        end
    end

    assign s1_cell       = cell_index(s1_word_reg.cell_row, s1_word_reg.cell_col, COLS_N);
    assign load_cmd.go   = s1_valid_reg && s1_load_reg;
    assign load_cmd.ch   = s1_word_reg.char_first;
    assign load_cmd.pos  = {s1_word_reg.cell_row, s1_word_reg.cell_col};
    assign load_cmd.slot = s1_cell;

    // char map: first char (also the loaded char) and second char
    assign pm_raddr[0] = req_word.char_first;
    assign pm_raddr[1] = req_word.char_second;

    pds_ram #(
        .DEPTH (NUM_CHARS),
        .WIDTH (POS_W),
        .NRD   (2)
    ) u_pos_mem (
        .clk   (clk),
        .we    (pos_we),
        .waddr (load_cmd.ch),
        .wdata (load_cmd.pos),
        .re    (req_acc),
        .raddr (pm_raddr),
        .rdata (pm_rdata)
    );

    // key square copy for the char a load replaces
    assign kb_raddr[0] = req_cell[CW-1:0];

    pds_ram #(
        .DEPTH (CELLS),
        .WIDTH (CHAR_W),
        .NRD   (1)
    ) u_key_old (
        .clk   (clk),
        .we    (load_cmd.go),
        .waddr (s1_cell[CW-1:0]),
        .wdata (load_cmd.ch),
        .re    (req_acc),
        .raddr (kb_raddr),
        .rdata (kb_rdata)
    );

    pds_cell_sel #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_cell_sel (
        .pos_first   (pm_rdata[0]),
        .pos_second  (pm_rdata[1]),
        .decrypt     (s1_word_reg.req_type == REQ_DEC),
        .cell_first  (tgt_cell[0]),
        .cell_second (tgt_cell[1])
    );

    assign ka_raddr[0] = tgt_cell[0][CW-1:0];
    assign ka_raddr[1] = tgt_cell[1][CW-1:0];

    pds_ram #(
        .DEPTH (CELLS),
        .WIDTH (CHAR_W),
        .NRD   (2)
    ) u_key_sub (
        .clk   (clk),
        .we    (load_cmd.go),
        .waddr (s1_cell[CW-1:0]),
        .wdata (load_cmd.ch),
        .re    (dg_go),
        .raddr (ka_raddr),
        .rdata (ka_rdata)
    );

    assign qry_ch[0] = s1_word_reg.char_first;
    assign qry_ch[1] = s1_word_reg.char_second;

    pds_map_state #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_map (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_cmd    (load_cmd),
        .old_rd      (kb_rdata[0]),
        .cur_rd      (pm_rdata[0]),
        .pos_we      (pos_we),
        .qry_ch      (qry_ch),
        .qry_present (qry_present),
        .qry_cell    (tgt_cell),
        .qry_written (qry_written)
    );

    // cells never loaded read as zero; a missing char zeroes both
    assign rsp_valid           = out_valid_reg;
    assign rsp_word.out_first  = (out_err_reg || !out_kv_reg[0]) ? '0 : ka_rdata[0];
    assign rsp_word.out_second = (out_err_reg || !out_kv_reg[1]) ? '0 : ka_rdata[1];
    assign rsp_word.status     = out_err_reg;

    a_dg_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_load_reg && !out_free)
        |=> (s1_valid_reg && !s1_load_reg && $stable(s1_word_reg)))
        else $error("waiting digraph lost from stage 1");

    a_no_write_on_sub_read: assert property (@(posedge clk) disable iff (!rst_n)
        dg_go |-> !load_cmd.go)
        else $error("key write during substitution read");

    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(s1_valid_reg && !s1_load_reg))
        else $error("result word without a digraph behind it");

endmodule
